// ----- src/triangle_tangent_binormal_macros.svh -----
// Assertion macros for the triangle tangent/binormal block.
// Used by the port checker; no other dependencies.
`ifndef TRIANGLE_TANGENT_BINORMAL_MACROS_SVH
`define TRIANGLE_TANGENT_BINORMAL_MACROS_SVH

// Same-cycle implication, disabled in reset
`define TTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttb check failed");

// Next-cycle implication, disabled in reset
`define TTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttb check failed");

`endif

// ----- src/ttb_pkg.sv -----
// Shared constants for the triangle tangent/binormal block.
// No dependencies; used by the top level and its checker.
package ttb_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FIELD_W         = 32;
  localparam int IN_DATA_W       = 5 * FIELD_W;
  localparam int OUT_W           = 16;
  localparam int OUT_DATA_W      = 6 * OUT_W;
  localparam int NORM_BITS       = 30;
  localparam int DIGIT_W         = 8;
  localparam int ITER_W          = 6;
  localparam int SQRT_STEPS      = 32;
  localparam int QUO_W           = 15;
  localparam int DIV_W           = 46;
  localparam int ONE_Q14         = 16384;
endpackage

// ----- src/triangle_tangent_binormal.sv -----
// Triangle tangent/binormal unit: shared digit-serial multiplier, sqrt and
// divider under one sequencer. Depends on ttb_pkg.
// Vertices 0 and 1 of a triangle are only stored; the third vertex starts the
// determinant, tangent and binormal products, normalization, square roots and
// divisions. The multiplier takes ND = ceil(max(COORD_WIDTH+1,30)/8) digits.
// A zero determinant or a zero vector ends the triangle early as degenerate.
// One triangle at a time; the result register frees the input side.
// Reset (async, active low) clears the vertex phase and the output valid.
module triangle_tangent_binormal #(
  parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each, lowest first)
  input  logic [ttb_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // mesh_start
  input  logic [0:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tangent_x/y/z, binormal_x/y/z (16 bits each, lowest first)
  output logic [ttb_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // degenerate
  output logic [0:0]                      m_axis_tuser_o
);
  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int NB  = ttb_pkg::NORM_BITS;
  localparam int DG  = ttb_pkg::DIGIT_W;
  localparam int MW  = (DW > NB) ? DW : NB;
  localparam int ND  = (MW + DG - 1) / DG;
  localparam int BW  = ND * DG;
  localparam int PRW = MW + BW;
  localparam int AW  = PRW + 2;
  localparam int IW  = ttb_pkg::ITER_W;
  localparam int FW  = ttb_pkg::FIELD_W;
  localparam int OW  = ttb_pkg::OUT_W;
  localparam int QW  = ttb_pkg::QUO_W;
  localparam int VW  = ttb_pkg::DIV_W;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_LOAD  = 10'b00_0000_0010,
    S_MUL   = 10'b00_0000_0100,
    S_ACC   = 10'b00_0000_1000,
    S_VLOAD = 10'b00_0001_0000,
    S_NORM  = 10'b00_0010_0000,
    S_SQRT  = 10'b00_0100_0000,
    S_DLOAD = 10'b00_1000_0000,
    S_DIV   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

  function automatic logic signed [CW-1:0] to_coord(input logic [FW-1:0] f);
    return signed'(CW'(f));
  endfunction

  function automatic logic [DW-1:0] mag_of(input logic signed [DW-1:0] x);
    return x[DW-1] ? DW'(-x) : DW'(x);
  endfunction

  // Control registers
  state_e          state_q, state_d;
  logic [1:0]      phase_q, phase_d;
  logic [3:0]      pi_q, pi_d;
  logic [1:0]      k_q, k_d;
  logic            vec_q, vec_d;
  logic            sq_q, sq_d;
  logic [IW-1:0]   it_q, it_d;
  logic            bad_q, bad_d;
  logic            detneg_q, detneg_d;
  logic            ovalid_q, ovalid_d;

  // Payload registers
  logic signed [CW-1:0] hpos_q [6];
  logic signed [CW-1:0] htex_q [4];
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [DW-1:0] d1u_q, d1v_q, d2u_q, d2v_q;
  logic [MW-1:0]        a_q;
  logic [BW-1:0]        b_q;
  logic [PRW-1:0]       prod_q;
  logic                 psub_q;
  logic signed [AW-1:0] acc_q;
  logic signed [AW-1:0] tv_q [3];
  logic signed [AW-1:0] bv_q [3];
  logic [AW-1:0]        m_q [3];
  logic                 neg_q [3];
  logic [63:0]          sv_q, sr_q, sb_q;
  logic [31:0]          len_q;
  logic [VW-1:0]        rem_q, dv_q;
  logic [QW-1:0]        quo_q;
  logic signed [OW-1:0] tres_q [3];
  logic signed [OW-1:0] bres_q [3];
  logic [ttb_pkg::OUT_DATA_W-1:0] odata_q;
  logic                 odeg_q;

  // Input unpack
  logic                 in_acc;
  logic                 mesh_start;
  logic signed [CW-1:0] cur_p [3];
  logic signed [CW-1:0] cur_t [2];
  logic [1:0]           in_phase;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign mesh_start      = s_axis_tuser_i[0];
  assign in_phase        = mesh_start ? 2'd0 : phase_q;

  always_comb begin
    for (int i = 0; i < 3; i++) cur_p[i] = to_coord(s_axis_tdata_i[i*FW +: FW]);
    for (int i = 0; i < 2; i++) cur_t[i] = to_coord(s_axis_tdata_i[(3+i)*FW +: FW]);
  end

  // Operand selection for the shared multiplier
  logic [2:0]           res_idx;
  logic [1:0]           comp;
  logic signed [DW-1:0] op_x, op_y;
  logic                 term_sub;

  assign res_idx = pi_q[3:1];

  always_comb begin
    comp = 2'd0;
    op_x = d1u_q;
    op_y = d2v_q;
    unique case (res_idx)
      3'd0: begin
        op_x = pi_q[0] ? d2u_q : d1u_q;
        op_y = pi_q[0] ? d1v_q : d2v_q;
      end
      3'd1, 3'd2, 3'd3: begin
        comp = 2'(res_idx - 3'd1);
        op_x = pi_q[0] ? d1v_q : d2v_q;
        op_y = pi_q[0] ? e2_q[comp] : e1_q[comp];
      end
      3'd4, 3'd5, 3'd6: begin
        comp = 2'(res_idx - 3'd4);
        op_x = pi_q[0] ? d2u_q : d1u_q;
        op_y = pi_q[0] ? e1_q[comp] : e2_q[comp];
      end
      default: begin
        op_x = d1u_q;
        op_y = d2v_q;
      end
    endcase
    term_sub = pi_q[0] ^ ((res_idx != 3'd0) && detneg_q);
  end

  // Digit step and accumulate
  logic [MW+DG-1:0]     pp;
  logic [PRW-1:0]       prod_d;
  logic signed [AW-1:0] addend, acc_sum;

  always_comb begin
    pp      = a_q * b_q[BW-1 -: DG];
    prod_d  = {prod_q[PRW-DG-1:0], {DG{1'b0}}} + PRW'(pp);
    addend  = psub_q ? -signed'(AW'(prod_q)) : signed'(AW'(prod_q));
    acc_sum = acc_q + addend;
  end

  // Vector load magnitudes
  logic [AW-1:0] vmag [3];
  logic          vneg [3];
  logic          vzero;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vneg[i] = vec_q ? bv_q[i][AW-1] : tv_q[i][AW-1];
      vmag[i] = vec_q ? (bv_q[i][AW-1] ? AW'(-bv_q[i]) : AW'(bv_q[i]))
                      : (tv_q[i][AW-1] ? AW'(-tv_q[i]) : AW'(tv_q[i]));
    end
    vzero = ((vmag[0] | vmag[1] | vmag[2]) == '0);
  end

  // Normalizing shift decision
  logic [AW-1:0] om;
  logic          nr8, nr1, nl8, nl1;

  always_comb begin
    om  = m_q[0] | m_q[1] | m_q[2];
    nr8 = |om[AW-1:NB+DG];
    nr1 = |om[AW-1:NB];
    nl8 = (om[AW-1:NB-DG] == '0);
    nl1 = !om[NB-1];
  end

  // Square-root step
  logic [63:0] sq_t, sv_d, sr_d;
  logic        sq_ge;

  always_comb begin
    sq_t  = sr_q + sb_q;
    sq_ge = (sv_q >= sq_t);
    sv_d  = sq_ge ? sv_q - sq_t : sv_q;
    sr_d  = sq_ge ? (sr_q >> 1) + sb_q : (sr_q >> 1);
  end

  // Division step and final clamp
  logic          dv_ge;
  logic [QW-1:0] quo_d, quo_c;
  logic [VW-1:0] num;

  always_comb begin
    dv_ge = (rem_q >= dv_q);
    quo_d = {quo_q[QW-2:0], dv_ge};
    quo_c = (quo_d > QW'(ttb_pkg::ONE_Q14)) ? QW'(ttb_pkg::ONE_Q14) : quo_d;
    num   = (VW'(m_q[k_q][NB-1:0]) << 14) + VW'(len_q >> 1);
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    pi_d     = pi_q;
    k_d      = k_q;
    vec_d    = vec_q;
    sq_d     = sq_q;
    it_d     = it_q;
    bad_d    = bad_q;
    detneg_d = detneg_q;
    ovalid_d = ovalid_q;
    if (m_axis_tready_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_phase < 2'd2) begin
            phase_d = in_phase + 2'd1;
          end else begin
            phase_d  = 2'd0;
            pi_d     = 4'd0;
            sq_d     = 1'b0;
            vec_d    = 1'b0;
            bad_d    = 1'b0;
            detneg_d = 1'b0;
            state_d  = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        it_d    = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        it_d = it_q + IW'(1);
        if (it_q == IW'(ND - 1)) state_d = S_ACC;
      end
      S_ACC: begin
        state_d = S_LOAD;
        if (sq_q) begin
          k_d = k_q + 2'd1;
          if (k_q == 2'd2) begin
            it_d    = '0;
            state_d = S_SQRT;
          end
        end else begin
          pi_d = pi_q + 4'd1;
          if (pi_q[0] && res_idx == 3'd0) begin
            detneg_d = acc_sum[AW-1];
            if (acc_sum == '0) begin
              bad_d   = 1'b1;
              state_d = S_OUT;
            end
          end
          if (pi_q == 4'd13) state_d = S_VLOAD;
        end
      end
      S_VLOAD: begin
        if (vzero) begin
          bad_d   = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (!nr1 && !nl1) begin
          k_d     = 2'd0;
          sq_d    = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_SQRT: begin
        it_d = it_q + IW'(1);
        if (it_q == IW'(ttb_pkg::SQRT_STEPS - 1)) begin
          k_d     = 2'd0;
          state_d = S_DLOAD;
        end
      end
      S_DLOAD: begin
        it_d    = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        it_d = it_q + IW'(1);
        if (it_q == IW'(QW - 1)) begin
          k_d     = k_q + 2'd1;
          state_d = S_DLOAD;
          if (k_q == 2'd2) begin
            if (vec_q) begin
              state_d = S_OUT;
            end else begin
              vec_d   = 1'b1;
              sq_d    = 1'b0;
              state_d = S_VLOAD;
            end
          end
        end
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= 2'd0;
      pi_q     <= 4'd0;
      k_q      <= 2'd0;
      vec_q    <= 1'b0;
      sq_q     <= 1'b0;
      it_q     <= '0;
      bad_q    <= 1'b0;
      detneg_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      pi_q     <= pi_d;
      k_q      <= k_d;
      vec_q    <= vec_d;
      sq_q     <= sq_d;
      it_q     <= it_d;
      bad_q    <= bad_d;
      detneg_q <= detneg_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Held vertices, held reset to zero as in the vertex store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) hpos_q[i] <= '0;
      for (int i = 0; i < 4; i++) htex_q[i] <= '0;
    end else if (in_acc && in_phase < 2'd2) begin
      for (int i = 0; i < 3; i++) begin
        if (in_phase == 2'd0) hpos_q[i] <= cur_p[i];
        else                  hpos_q[3+i] <= cur_p[i];
      end
      for (int i = 0; i < 2; i++) begin
        if (in_phase == 2'd0) htex_q[i] <= cur_t[i];
        else                  htex_q[2+i] <= cur_t[i];
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_phase == 2'd2) begin
          for (int i = 0; i < 3; i++) begin
            e1_q[i] <= DW'(hpos_q[3+i]) - DW'(hpos_q[i]);
            e2_q[i] <= DW'(cur_p[i]) - DW'(hpos_q[i]);
          end
          d1u_q <= DW'(htex_q[2]) - DW'(htex_q[0]);
          d1v_q <= DW'(htex_q[3]) - DW'(htex_q[1]);
          d2u_q <= DW'(cur_t[0]) - DW'(htex_q[0]);
          d2v_q <= DW'(cur_t[1]) - DW'(htex_q[1]);
          acc_q <= '0;
        end
      end
      S_LOAD: begin
        prod_q <= '0;
        if (sq_q) begin
          a_q    <= MW'(m_q[k_q][NB-1:0]);
          b_q    <= BW'(m_q[k_q][NB-1:0]);
          psub_q <= 1'b0;
        end else begin
          a_q    <= MW'(mag_of(op_x));
          b_q    <= BW'(mag_of(op_y));
          psub_q <= term_sub ^ op_x[DW-1] ^ op_y[DW-1];
        end
      end
      S_MUL: begin
        prod_q <= prod_d;
        b_q    <= b_q << DG;
      end
      S_ACC: begin
        if (sq_q) begin
          acc_q <= acc_sum;
          if (k_q == 2'd2) begin
            sv_q <= 64'(acc_sum);
            sr_q <= '0;
            sb_q <= 64'h4000_0000_0000_0000;
          end
        end else if (pi_q[0]) begin
          acc_q <= '0;
          if (res_idx >= 3'd1 && res_idx <= 3'd3) tv_q[comp] <= acc_sum;
          if (res_idx >= 3'd4 && res_idx <= 3'd6) bv_q[comp] <= acc_sum;
        end else begin
          acc_q <= acc_sum;
        end
      end
      S_VLOAD: begin
        acc_q <= '0;
        for (int i = 0; i < 3; i++) begin
          m_q[i]   <= vmag[i];
          neg_q[i] <= vneg[i];
        end
      end
      S_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (nr8)      m_q[i] <= m_q[i] >> DG;
          else if (nr1) m_q[i] <= m_q[i] >> 1;
          else if (nl8) m_q[i] <= m_q[i] << DG;
          else if (nl1) m_q[i] <= m_q[i] << 1;
        end
      end
      S_SQRT: begin
        sv_q <= sv_d;
        sr_q <= sr_d;
        sb_q <= sb_q >> 2;
        if (it_q == IW'(ttb_pkg::SQRT_STEPS - 1)) len_q <= 32'(sr_d);
      end
      S_DLOAD: begin
        rem_q <= num;
        dv_q  <= VW'(len_q) << (QW - 1);
        quo_q <= '0;
      end
      S_DIV: begin
        if (dv_ge) rem_q <= rem_q - dv_q;
        dv_q  <= dv_q >> 1;
        quo_q <= quo_d;
        if (it_q == IW'(QW - 1)) begin
          if (vec_q) bres_q[k_q] <= neg_q[k_q] ? -signed'(OW'(quo_c)) : signed'(OW'(quo_c));
          else       tres_q[k_q] <= neg_q[k_q] ? -signed'(OW'(quo_c)) : signed'(OW'(quo_c));
        end
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready_i) begin
          odeg_q  <= bad_q;
          odata_q <= bad_q ? '0 : {bres_q[2], bres_q[1], bres_q[0],
                                   tres_q[2], tres_q[1], tres_q[0]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = odeg_q;
endmodule

// ----- src/ttb_checker.sv -----
// Port-level checker for the triangle tangent/binormal block, bound to it.
// Depends on ttb_pkg and triangle_tangent_binormal_macros.svh.
`include "triangle_tangent_binormal_macros.svh"
module ttb_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [ttb_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [0:0]                     s_axis_tuser_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [ttb_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]                     m_axis_tuser_o
);
  // Stalled result transaction holds
  `TTB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  // Degenerate results carry zero vectors
  `TTB_ASSERT_IMP(a_deg_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o == '0)
  // A good result carries unit vectors, never all zero
  `TTB_ASSERT_IMP(a_good_nonzero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o[0], m_axis_tdata_o != '0)
  // A new result appears only after the input side was busy computing
  `TTB_ASSERT_IMP(a_rise_busy, clk_i, rst_ni, $rose(m_axis_tvalid_o), $past(!s_axis_tready_o))
endmodule

bind triangle_tangent_binormal ttb_checker u_ttb_checker (.*);
